// File: rtl/mlfq_pkg.sv
package mlfq_pkg;

	localparam int PID_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int ENTRY_W = PID_W + 2 * TIME_W;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic REG_TICK_STEP  = 1'b0;
	localparam logic REG_TIME_SLICE = 1'b1;

	typedef struct packed {
		logic ld;
		logic exec;
		logic sel;
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic disp_need;
		logic out_free;
	} status_t;

endpackage

// File: rtl/mlfq_ram.sv
module mlfq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: rtl/mlfq_dp.sv
module mlfq_dp #(
	parameter int NUM_LEVELS  = 3,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mlfq_pkg::cmd_t               cmd,
	output mlfq_pkg::status_t            status,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mlfq_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         action,
	input  logic [mlfq_pkg::PID_W-1:0]   task_pid,
	input  logic [mlfq_pkg::TIME_W-1:0]  task_duration_ms,
	input  logic                         task_runnable,
	input  logic [mlfq_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         done_valid,
	output logic [mlfq_pkg::PID_W-1:0]   done_pid,
	output logic [mlfq_pkg::TIME_W-1:0]  done_time_ms,
	output logic                         running_valid,
	output logic [mlfq_pkg::PID_W-1:0]   running_pid,
	output logic [2:0]                   running_level,
	output logic                         add_dropped
);

	localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int LW    = $clog2(NUM_LEVELS);
	localparam int PW    = $clog2(LEVEL_DEPTH);
	localparam int CW    = $clog2(LEVEL_DEPTH + 1);
	localparam int TW    = mlfq_pkg::TIME_W;

	logic [mlfq_pkg::CFG_W-1:0] tick_step_q, slice_len_q;
	logic          act_q, runnable_q;
	logic [mlfq_pkg::PID_W-1:0] pid_q;
	logic [TW-1:0] dur_q, now_q;

	logic          busy_q;
	logic [mlfq_pkg::PID_W-1:0] cur_pid_q, done_pid_q;
	logic [TW-1:0] cur_req_q, cur_ela_q, slice_begin_q;
	logic [LW-1:0] cur_level_q, sel_lvl_q;
	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [PW-1:0] tail_q [NUM_LEVELS];
	logic [CW-1:0] count_q [NUM_LEVELS];
	logic          done_q, dropped_q;

	logic          out_valid_q;
	logic          o_done_q, o_run_q, o_drop_q;
	logic [mlfq_pkg::PID_W-1:0] o_dpid_q, o_rpid_q;
	logic [TW-1:0] o_dtime_q;
	logic [2:0]    o_lvl_q;

	logic [TW:0]   sum;
	logic [TW-1:0] ela_n, since;
	logic          fin, expired, add_ok, dem_ok;
	logic [LW-1:0] nl, sel;
	logic          found;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [mlfq_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		nxt = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [PW-1:0] p);
		slot = AW'(l) * AW'(LEVEL_DEPTH) + AW'(p);
	endfunction

	always_comb begin
		sum     = {1'b0, cur_ela_q} + {{(TW + 1 - mlfq_pkg::CFG_W){1'b0}}, tick_step_q};
		ela_n   = sum[TW] ? '1 : sum[TW-1:0];
		fin     = ela_n >= cur_req_q;
		since   = now_q - slice_begin_q;
		expired = since >= TW'(slice_len_q);
		nl      = (cur_level_q == LW'(NUM_LEVELS - 1)) ? cur_level_q : cur_level_q + 1'b1;
		add_ok  = runnable_q && (count_q[0] != CW'(LEVEL_DEPTH));
		dem_ok  = busy_q && !fin && expired && (count_q[nl] != CW'(LEVEL_DEPTH));
		sel     = '0;
		found   = 1'b0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				sel   = LW'(l);
				found = 1'b1;
			end
		end
		mem_we    = 1'b0;
		mem_addr  = slot(sel, head_q[sel]);
		mem_wdata = {cur_pid_q, cur_req_q, ela_n};
		if (cmd.exec) begin
			if (act_q == mlfq_pkg::ACT_ADD) begin
				mem_we    = add_ok;
				mem_addr  = slot('0, tail_q[0]);
				mem_wdata = {pid_q, dur_q, {TW{1'b0}}};
			end else begin
				mem_we   = dem_ok;
				mem_addr = slot(nl, tail_q[nl]);
			end
		end
	end

	mlfq_ram #(
		.WIDTH (mlfq_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			act_q      <= action;
			pid_q      <= task_pid;
			dur_q      <= task_duration_ms;
			runnable_q <= task_runnable;
			now_q      <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q   <= mlfq_pkg::CFG_W'(1);
			slice_len_q   <= mlfq_pkg::CFG_W'(10);
			busy_q        <= 1'b0;
			cur_pid_q     <= '0;
			done_pid_q    <= '0;
			cur_req_q     <= '0;
			cur_ela_q     <= '0;
			slice_begin_q <= '0;
			cur_level_q   <= '0;
			sel_lvl_q     <= '0;
			done_q        <= 1'b0;
			dropped_q     <= 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == mlfq_pkg::REG_TICK_STEP) begin
					tick_step_q <= cfg_wdata;
				end else begin
					slice_len_q <= cfg_wdata;
				end
			end
			if (cmd.exec) begin
				done_q     <= (act_q == mlfq_pkg::ACT_TICK) && busy_q && fin;
				dropped_q  <= (act_q == mlfq_pkg::ACT_ADD) && runnable_q && !add_ok;
				done_pid_q <= cur_pid_q;
				if (act_q == mlfq_pkg::ACT_ADD) begin
					if (add_ok) begin
						tail_q[0]  <= nxt(tail_q[0]);
						count_q[0] <= count_q[0] + 1'b1;
					end
				end else if (busy_q) begin
					cur_ela_q <= ela_n;
					if (fin) begin
						busy_q <= 1'b0;
					end else if (expired) begin
						if (dem_ok) begin
							busy_q      <= 1'b0;
							tail_q[nl]  <= nxt(tail_q[nl]);
							count_q[nl] <= count_q[nl] + 1'b1;
						end else begin
							slice_begin_q <= now_q;
						end
					end
				end
			end
			if (cmd.sel) begin
				sel_lvl_q      <= sel;
				head_q[sel]    <= nxt(head_q[sel]);
				count_q[sel]   <= count_q[sel] - 1'b1;
				slice_begin_q  <= now_q;
			end
			if (cmd.load) begin
				busy_q      <= 1'b1;
				cur_level_q <= sel_lvl_q;
				{cur_pid_q, cur_req_q, cur_ela_q} <= mem_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_done_q  <= done_q;
			o_dpid_q  <= done_q ? done_pid_q : '0;
			o_dtime_q <= done_q ? now_q : '0;
			o_run_q   <= busy_q;
			o_rpid_q  <= busy_q ? cur_pid_q : '0;
			o_lvl_q   <= busy_q ? 3'(cur_level_q) : '0;
			o_drop_q  <= dropped_q;
		end
	end

	assign status.disp_need = (act_q == mlfq_pkg::ACT_TICK) && !busy_q && found;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign done_valid    = o_done_q;
	assign done_pid      = o_dpid_q;
	assign done_time_ms  = o_dtime_q;
	assign running_valid = o_run_q;
	assign running_pid   = o_rpid_q;
	assign running_level = o_lvl_q;
	assign add_dropped   = o_drop_q;

	a_count0_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= CW'(LEVEL_DEPTH))
		else $error("level 0 count overflow");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy_q)
		else $error("dispatch did not occupy cpu");

	a_sel_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel |-> (found && !busy_q))
		else $error("dispatch from empty queues or busy cpu");

	a_drop_add: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && dropped_q |-> !done_q)
		else $error("drop and finish in one word");

endmodule

// File: rtl/mlfq_ctrl.sv
module mlfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mlfq_pkg::status_t status,
	output mlfq_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DISP,
		S_LOAD,
		S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= S_DISP;
				S_DISP: state_q <= status.disp_need ? S_LOAD : S_EMIT;
				S_LOAD: state_q <= S_EMIT;
				S_EMIT: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.ld   = in_ready && in_valid;
		cmd.exec = (state_q == S_EXEC);
		cmd.sel  = (state_q == S_DISP) && status.disp_need;
		cmd.load = (state_q == S_LOAD);
		cmd.emit = (state_q == S_EMIT) && status.out_free;
	end

	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld |=> cmd.exec)
		else $error("accepted word not executed");

endmodule

// File: rtl/mlfq_task_scheduler_top.sv
// Multilevel feedback queue scheduler. Each input word is either an add (queue a runnable
// task at the tail of level 0, flagging add_dropped when level 0 is full) or a tick (advance
// the running task, retire or demote it, then, if no task runs, dispatch the head of the
// lowest-numbered non-empty level). Every word gives exactly one result word. A word's result
// is loaded into the output register after the exec and dispatch states, and after a load
// state too when a tick dispatches a task: the queues share one single-port task memory, so a
// demotion write, the head read and its registered read data fall in separate cycles. The next
// word is taken in the cycle after the result is registered, so no word is accepted while
// another is in flight; a result not yet taken holds the following one in its last cycle.
// Configuration writes take effect at once and belong between words.
module mlfq_task_scheduler_top #(
	parameter int NUM_LEVELS  = 3,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mlfq_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [mlfq_pkg::PID_W-1:0]   task_pid,
	input  logic [mlfq_pkg::TIME_W-1:0]  task_duration_ms,
	input  logic                         task_runnable,
	input  logic [mlfq_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         done_valid,
	output logic [mlfq_pkg::PID_W-1:0]   done_pid,
	output logic [mlfq_pkg::TIME_W-1:0]  done_time_ms,
	output logic                         running_valid,
	output logic [mlfq_pkg::PID_W-1:0]   running_pid,
	output logic [2:0]                   running_level,
	output logic                         add_dropped
);

	mlfq_pkg::cmd_t    cmd;
	mlfq_pkg::status_t status;

	mlfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mlfq_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.action           (action),
		.task_pid         (task_pid),
		.task_duration_ms (task_duration_ms),
		.task_runnable    (task_runnable),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.done_valid       (done_valid),
		.done_pid         (done_pid),
		.done_time_ms     (done_time_ms),
		.running_valid    (running_valid),
		.running_pid      (running_pid),
		.running_level    (running_level),
		.add_dropped      (add_dropped)
	);

endmodule
